[sv/redundant_edge_union_find_core_defines.svh]
// Assertion macros for the redundant edge union-find core.
// Used by the top level; relies on clk and rst_n in scope.
`ifndef REDUNDANT_EDGE_UNION_FIND_CORE_DEFINES_SVH
`define REDUNDANT_EDGE_UNION_FIND_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define REUF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("reuf: same-cycle check failed");
`define REUF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("reuf: next-cycle check failed");
`else
`define REUF_ASSERT_IMP(label, ante, cons)
`define REUF_ASSERT_NXT(label, ante, cons)
`endif

`endif

[sv/reuf_pkg.sv]
// Shared constants and types for the redundant edge union-find core.
// No dependencies.
`timescale 1ns / 1ps

package reuf_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int RANK_W     = 4;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [RANK_W-1:0] rank_t;

    localparam rank_t RANK_MAX = {RANK_W{1'b1}};
    localparam node_t NODE_LAST = NODE_W'(NODE_COUNT - 1);

    typedef struct packed {
        rank_t rank;
        node_t parent;
    } node_entry_t;

    typedef struct packed {
        logic        clear;
        node_t       rd_addr;
        logic        wr_en;
        node_t       wr_addr;
        node_entry_t wr_data;
    } mem_req_t;

    typedef struct packed {
        logic        busy;
        node_entry_t rd_data;
    } mem_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_WALK_A,
        S_WALK_B,
        S_RANK,
        S_DONE
    } state_t;

endpackage

[sv/reuf_edge_if.sv]
// Edge input channel: valid/ready plus the edge payload.
// Depends on reuf_pkg.
`timescale 1ns / 1ps

interface reuf_edge_if
    import reuf_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  new_graph;
    node_t node_first;
    node_t node_second;

    modport source (output valid, output new_graph, output node_first, output node_second,
                    input ready);
    modport sink   (input valid, input new_graph, input node_first, input node_second,
                    output ready);
endinterface

[sv/reuf_result_if.sv]
// Result channel: valid/ready plus redundant flag and stored answer.
// Depends on reuf_pkg.
`timescale 1ns / 1ps

interface reuf_result_if
    import reuf_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  is_redundant;
    node_t answer_first;
    node_t answer_second;

    modport source (output valid, output is_redundant, output answer_first,
                    output answer_second, input ready);
    modport sink   (input valid, input is_redundant, input answer_first,
                    input answer_second, output ready);
endinterface

[sv/reuf_forest_ram.sv]
// Forest RAM: parent and rank per node, one read and one write port,
// registered read, plus the clearing sweep. Depends on reuf_pkg.
`timescale 1ns / 1ps

module reuf_forest_ram
    import reuf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t req,
    output mem_rsp_t rsp
);

    node_entry_t mem [NODE_COUNT];
    node_entry_t rd_data_reg;

    logic  clr_active_reg, clr_active_next;
    node_t clr_addr_reg, clr_addr_next;

    logic        we;
    node_t       waddr;
    node_entry_t wdata;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == NODE_LAST)
            begin
                clr_active_next = 1'b0;
            end
        end
        else if (req.clear)
        begin
            clr_active_next = 1'b1;
            clr_addr_next   = '0;
        end
    end

    always_comb
    begin
        if (clr_active_reg)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
            wdata = '{rank: '0, parent: clr_addr_reg};
        end
        else
        begin
            we    = req.wr_en;
            waddr = req.wr_addr;
            wdata = req.wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rsp.busy    = clr_active_reg;
    assign rsp.rd_data = rd_data_reg;

endmodule

[sv/redundant_edge_union_find_core.sv]
// Top level: union-find redundant edge detector, one walk step per cycle.
// The walk follows parent links from each endpoint to its root through the single
// forest RAM read port; a rank rise adds the S_RANK write before the result registers.
// Next edge can be taken in the cycle after the result registers.
// After reset a sweep clears all 1024 RAM entries with ready low; a new_graph edge
// runs the same sweep before its walk.
`timescale 1ns / 1ps
`include "redundant_edge_union_find_core_defines.svh"

module redundant_edge_union_find_core
    import reuf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    reuf_edge_if.sink     edges,
    reuf_result_if.source results
);

    mem_req_t mem_req;
    mem_rsp_t mem_rsp;

    state_t state_reg, state_next;

    node_t first_reg, first_next;
    node_t second_reg, second_next;
    node_t cur_reg, cur_next;
    node_t root_a_reg, root_a_next;
    rank_t rank_a_reg, rank_a_next;
    node_t hi_reg, hi_next;
    rank_t hi_rank_reg, hi_rank_next;
    logic  hit_reg, hit_next;
    node_t saved_first_reg, saved_first_next;
    node_t saved_second_reg, saved_second_next;

    logic  out_valid_reg, out_valid_next;
    logic  out_hit_reg;
    node_t out_first_reg;
    node_t out_second_reg;

    logic  take;
    logic  at_root;
    logic  a_low;
    logic  bump;
    logic  res_load;
    node_t hi_node, lo_node;
    rank_t hi_rank, lo_rank;

    reuf_forest_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rsp   (mem_rsp)
    );

    assign edges.ready = (state_reg == S_IDLE) && !mem_rsp.busy;
    assign take        = edges.valid && edges.ready;
    assign at_root     = (mem_rsp.rd_data.parent == cur_reg);
    assign res_load    = (state_reg == S_DONE) && (!out_valid_reg || results.ready);

    // union: lower rank root goes under the other; first root wins ties
    assign a_low   = rank_a_reg < mem_rsp.rd_data.rank;
    assign hi_node = a_low ? cur_reg : root_a_reg;
    assign lo_node = a_low ? root_a_reg : cur_reg;
    assign hi_rank = a_low ? mem_rsp.rd_data.rank : rank_a_reg;
    assign lo_rank = a_low ? rank_a_reg : mem_rsp.rd_data.rank;
    assign bump    = (rank_a_reg == mem_rsp.rd_data.rank) && (hi_rank != RANK_MAX);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = edges.new_graph ? S_CLEAR : S_WALK_A;
                end
            end
            S_CLEAR:
            begin
                if (!mem_rsp.busy)
                begin
                    state_next = S_WALK_A;
                end
            end
            S_WALK_A:
            begin
                if (at_root)
                begin
                    state_next = S_WALK_B;
                end
            end
            S_WALK_B:
            begin
                if (at_root)
                begin
                    if (cur_reg != root_a_reg && bump)
                    begin
                        state_next = S_RANK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RANK:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_req           = '0;
        mem_req.rd_addr   = cur_reg;
        first_next        = first_reg;
        second_next       = second_reg;
        cur_next          = cur_reg;
        root_a_next       = root_a_reg;
        rank_a_next       = rank_a_reg;
        hi_next           = hi_reg;
        hi_rank_next      = hi_rank_reg;
        hit_next          = hit_reg;
        saved_first_next  = saved_first_reg;
        saved_second_next = saved_second_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    first_next      = edges.node_first;
                    second_next     = edges.node_second;
                    cur_next        = edges.node_first;
                    mem_req.rd_addr = edges.node_first;
                    if (edges.new_graph)
                    begin
                        mem_req.clear     = 1'b1;
                        saved_first_next  = '0;
                        saved_second_next = '0;
                    end
                end
            end
            S_CLEAR:
            begin
                cur_next        = first_reg;
                mem_req.rd_addr = first_reg;
            end
            S_WALK_A:
            begin
                if (at_root)
                begin
                    root_a_next     = cur_reg;
                    rank_a_next     = mem_rsp.rd_data.rank;
                    cur_next        = second_reg;
                    mem_req.rd_addr = second_reg;
                end
                else
                begin
                    cur_next        = mem_rsp.rd_data.parent;
                    mem_req.rd_addr = mem_rsp.rd_data.parent;
                end
            end
            S_WALK_B:
            begin
                if (at_root)
                begin
                    if (cur_reg == root_a_reg)
                    begin
                        hit_next          = 1'b1;
                        saved_first_next  = first_reg;
                        saved_second_next = second_reg;
                    end
                    else
                    begin
                        hit_next        = 1'b0;
                        hi_next         = hi_node;
                        hi_rank_next    = hi_rank + 1'b1;
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = lo_node;
                        mem_req.wr_data = '{rank: lo_rank, parent: hi_node};
                    end
                end
                else
                begin
                    cur_next        = mem_rsp.rd_data.parent;
                    mem_req.rd_addr = mem_rsp.rd_data.parent;
                end
            end
            S_RANK:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = hi_reg;
                mem_req.wr_data = '{rank: hi_rank_reg, parent: hi_reg};
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            saved_first_reg  <= '0;
            saved_second_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            saved_first_reg  <= saved_first_next;
            saved_second_reg <= saved_second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg   <= first_next;
        second_reg  <= second_next;
        cur_reg     <= cur_next;
        root_a_reg  <= root_a_next;
        rank_a_reg  <= rank_a_next;
        hi_reg      <= hi_next;
        hi_rank_reg <= hi_rank_next;
        hit_reg     <= hit_next;
        if (res_load)
        begin
            out_hit_reg    <= hit_reg;
            out_first_reg  <= saved_first_reg;
            out_second_reg <= saved_second_reg;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.is_redundant  = out_hit_reg;
    assign results.answer_first  = out_first_reg;
    assign results.answer_second = out_second_reg;

    `REUF_ASSERT_NXT(a_clear_starts, take && edges.new_graph, state_reg == S_CLEAR && mem_rsp.busy)
    `REUF_ASSERT_IMP(a_result_from_done, $rose(results.valid), $past(state_reg) == S_DONE)
    `REUF_ASSERT_IMP(a_sweep_owns_ram, mem_rsp.busy, !mem_req.wr_en && !edges.ready)

endmodule

[tb/redundant_edge_union_find_core_tb.sv]
// Testbench for redundant_edge_union_find_core: edges in, redundancy verdicts out.
// Checks every verdict against its own union-by-rank forest model.
// Depends on reuf_pkg, reuf_edge_if, reuf_result_if and the core itself.
`timescale 1ns / 1ps

module redundant_edge_union_find_core_tb;
    import reuf_pkg::*;

    localparam int RANDOM_EDGES = 1950;
    localparam int STALL_AT     = 400;
    localparam int STALL_CYCLES = 300;
    localparam int TAIL_CYCLES  = 40;

    typedef struct packed {
        logic  is_redundant;
        node_t answer_first;
        node_t answer_second;
    } verdict_t;

    class edge_cycle_tracker;
        node_t       parent_of [NODE_COUNT];
        rank_t       tree_rank [NODE_COUNT];
        node_t       kept_first;
        node_t       kept_second;
        verdict_t    pending [$];
        int unsigned mismatches;
        int unsigned edges_seen;
        int unsigned cycles_found;
        int unsigned clears;
        int unsigned verdicts_checked;

        function new();
            clear_forest();
        endfunction

        function void clear_forest();
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                parent_of[i] = node_t'(i);
                tree_rank[i] = '0;
            end
            kept_first  = '0;
            kept_second = '0;
        endfunction

        function node_t root_of(node_t n);
            node_t walk;
            walk = n;
            for (int s = 0; s < NODE_COUNT; s++)
            begin
                if (parent_of[walk] == walk)
                    break;
                walk = parent_of[walk];
            end
            return walk;
        endfunction

        function void note_edge(logic fresh, node_t a, node_t b);
            verdict_t v;
            node_t    ra;
            node_t    rb;
            node_t    hi;
            node_t    lo;
            if (fresh)
            begin
                clear_forest();
                clears++;
            end
            ra = root_of(a);
            rb = root_of(b);
            v.is_redundant = (ra == rb);
            if (ra == rb)
            begin
                kept_first  = a;
                kept_second = b;
                cycles_found++;
            end
            else
            begin
                hi = ra;
                lo = rb;
                if (tree_rank[ra] < tree_rank[rb])
                begin
                    hi = rb;
                    lo = ra;
                end
                parent_of[lo] = hi;
                if (tree_rank[hi] == tree_rank[lo] && tree_rank[hi] != RANK_MAX)
                    tree_rank[hi] = tree_rank[hi] + 1'b1;
            end
            v.answer_first  = kept_first;
            v.answer_second = kept_second;
            pending.push_back(v);
            edges_seen++;
        endfunction

        function void note_mismatch(string what, verdict_t want, verdict_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%t: %s: expected red=%0b ans=(%0d,%0d), got red=%0b ans=(%0d,%0d)",
                         $realtime, what, want.is_redundant, want.answer_first,
                         want.answer_second, got.is_redundant, got.answer_first,
                         got.answer_second);
        endfunction

        function void check_verdict(logic red, node_t af, node_t as);
            verdict_t want;
            verdict_t got;
            got.is_redundant  = red;
            got.answer_first  = af;
            got.answer_second = as;
            verdicts_checked++;
            if (pending.size() == 0)
            begin
                note_mismatch("verdict with no edge pending", '0, got);
                return;
            end
            want = pending.pop_front();
            if (got.is_redundant !== want.is_redundant)
                note_mismatch("is_redundant wrong", want, got);
            else if (got.answer_first !== want.answer_first)
                note_mismatch("answer_first wrong", want, got);
            else if (got.answer_second !== want.answer_second)
                note_mismatch("answer_second wrong", want, got);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic steady;
    int   results_taken = 0;
    int   stall_left = 0;

    edge_cycle_tracker tracker = new();

    reuf_edge_if   edge_ch ();
    reuf_result_if verdict_ch ();

    redundant_edge_union_find_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .edges   (edge_ch),
        .results (verdict_ch)
    );

    always #5 clk = ~clk;

    // Receiver: random back-pressure plus one long hold-off once traffic is flowing.
    always @(posedge clk)
    begin
        if (rst_n && verdict_ch.valid && verdict_ch.ready)
        begin
            tracker.check_verdict(verdict_ch.is_redundant, verdict_ch.answer_first,
                                  verdict_ch.answer_second);
            results_taken++;
            if (results_taken == STALL_AT)
                stall_left = STALL_CYCLES;
        end
        if (!rst_n)
            verdict_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            verdict_ch.ready <= 1'b0;
        end
        else
            verdict_ch.ready <= steady || ($urandom_range(99) >= 28);
    end

    task automatic send_edge(input logic fresh, input node_t a, input node_t b);
        if (!steady)
        begin
            while ($urandom_range(99) < 28)
            begin
                edge_ch.valid       <= 1'b0;
                edge_ch.new_graph   <= 1'($urandom_range(1));
                edge_ch.node_first  <= node_t'($urandom);
                edge_ch.node_second <= node_t'($urandom);
                @(posedge clk);
            end
        end
        edge_ch.valid       <= 1'b1;
        edge_ch.new_graph   <= fresh;
        edge_ch.node_first  <= a;
        edge_ch.node_second <= b;
        do
            @(posedge clk);
        while (!edge_ch.ready);
        tracker.note_edge(fresh, a, b);
    endtask

    task automatic drain();
        edge_ch.valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        node_t pool [$];
        node_t a;
        node_t b;
        int    sent;
        int    graph_idx;
        int    pool_size;
        int    graph_len;
        int    pick;
        logic  fresh;

        clk                 = 1'b0;
        rst_n               = 1'b0;
        steady              = 1'b0;
        edge_ch.valid       = 1'b0;
        edge_ch.new_graph   = 1'b0;
        edge_ch.node_first  = '0;
        edge_ch.node_second = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset-state forest, extreme nodes, self loops, clears, rank ties.
        send_edge(1'b0, '0, NODE_LAST);
        send_edge(1'b0, NODE_LAST, '0);
        send_edge(1'b0, NODE_LAST, NODE_LAST);
        send_edge(1'b1, '0, '0);
        send_edge(1'b0, 10'd1, 10'd2);
        send_edge(1'b1, 10'd1, 10'd2);
        send_edge(1'b1, 10'd0, 10'd1);
        send_edge(1'b0, 10'd2, 10'd3);
        send_edge(1'b0, 10'd4, 10'd5);
        send_edge(1'b0, 10'd6, 10'd7);
        send_edge(1'b0, 10'd1, 10'd3);
        send_edge(1'b0, 10'd5, 10'd7);
        send_edge(1'b0, 10'd3, 10'd7);
        send_edge(1'b0, 10'd0, 10'd6);
        send_edge(1'b0, 10'd8, 10'd1);
        send_edge(1'b0, 10'd2, 10'd9);
        send_edge(1'b0, 10'd9, 10'd8);
        send_edge(1'b0, 10'd7, 10'd7);
        send_edge(1'b0, 10'd682, 10'd341);
        send_edge(1'b0, 10'd341, 10'd682);
        send_edge(1'b1, NODE_LAST, 10'd1022);
        send_edge(1'b0, 10'd1022, NODE_LAST);
        drain();

        // Random graphs: mostly edges within a small node pool, some noise.
        sent      = 0;
        graph_idx = 0;
        while (sent < RANDOM_EDGES)
        begin
            steady = (graph_idx >= 6 && graph_idx < 10);
            if ($urandom_range(9) == 0)
            begin
                pool_size = $urandom_range(64, 256);
                graph_len = $urandom_range(100, 300);
            end
            else
            begin
                pool_size = $urandom_range(2, 24);
                graph_len = $urandom_range(8, 60);
            end
            pool.delete();
            repeat (pool_size)
                pool.push_back(node_t'($urandom_range(NODE_COUNT - 1)));
            if ($urandom_range(3) == 0)
            begin
                pool.push_back('0);
                pool.push_back(NODE_LAST);
            end
            fresh = ($urandom_range(4) != 0);
            for (int k = 0; k < graph_len && sent < RANDOM_EDGES; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 85)
                begin
                    a = pool[$urandom_range(pool.size() - 1)];
                    b = pool[$urandom_range(pool.size() - 1)];
                end
                else if (pick < 95)
                begin
                    a = node_t'($urandom);
                    b = node_t'($urandom);
                end
                else
                begin
                    a = pool[$urandom_range(pool.size() - 1)];
                    b = a;
                end
                send_edge((fresh && k == 0) || $urandom_range(199) == 0, a, b);
                sent++;
            end
            if (graph_idx == 3)
                drain();
            graph_idx++;
        end
        steady = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d edges over %0d cleared graphs; %0d closed a cycle.",
                 tracker.edges_seen, tracker.clears, tracker.cycles_found);
        $display("Checked %0d verdicts, %0d mismatches.",
                 tracker.verdicts_checked, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/reuf_pkg.sv
sv/reuf_edge_if.sv
sv/reuf_result_if.sv
sv/reuf_forest_ram.sv
sv/redundant_edge_union_find_core.sv
tb/redundant_edge_union_find_core_tb.sv
